// File: rtl/pwmp_pkg.sv
// Package for the padded window max pool block: widths, register indexes,
// payload structs, controller states and cell control.
// No dependencies.
package pwmp_pkg;

	localparam int DATA_BITS      = 16;
	localparam int ROW_BITS       = 13;
	localparam int KERNEL_BITS    = 3;
	localparam int CHAN_REG_BITS  = 7;
	localparam int WIDTH_REG_BITS = 7;
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 3;

	localparam int DEF_MAX_WIDTH    = 64;
	localparam int DEF_MAX_CHANNELS = 64;
	localparam int DEF_MAX_KERNEL   = 5;

	// most negative sample: the value of a window with no position on the map
	localparam logic signed [DATA_BITS-1:0] DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNELS = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PAD      = 3'd4;

	// input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_DRAIN  = 1'b1;

	typedef struct packed {
		logic                        action;
		logic signed [DATA_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] pooled;
		logic                        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;
		logic en;
	} cell_ctl_t;

endpackage

// File: rtl/pwmp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; no other dependencies.
interface pwmp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/pwmp_bank.sv
// One bank of the row store: single write port, one registered read port.
// Depends on nothing; instantiated by the top level once per column residue.
module pwmp_bank #(
	parameter int AW = 12,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/pwmp_cell.sv
// Window column cell: keeps the running maximum of its column over the rows
// read so far and folds it into the maximum handed along the chain.
// Depends on pwmp_pkg.
module pwmp_cell (
	input  logic                                 clk,
	input  pwmp_pkg::cell_ctl_t                  ctl,
	input  logic signed [pwmp_pkg::DATA_BITS-1:0] din,
	input  logic signed [pwmp_pkg::DATA_BITS-1:0] chain_in,
	output logic signed [pwmp_pkg::DATA_BITS-1:0] chain_out
);
	import pwmp_pkg::*;

	logic signed [DATA_BITS-1:0] acc_q;

	// clear at window start, fold one row per enabled cycle
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= DATA_MIN;
		end else if (ctl.en && din > acc_q) begin
			acc_q <= din;
		end
	end

	// pass the larger value on to the next cell
	assign chain_out = (acc_q > chain_in) ? acc_q : chain_in;
endmodule

// File: rtl/padded_window_max_pool.sv
// Top level of the padded window max pool: config registers, raster counters,
// banked row store, controller and the chain of window column cells.
// Depends on pwmp_pkg, pwmp_stream_if, pwmp_bank and pwmp_cell.
//
//  Port      Dir  Payload            Transfer when
//  in_ch     in   action, sample     valid & ready
//  out_ch    out  pooled, last       valid & ready
//  cfg_*     in   index, data        cfg_we high
//
// An item with a ready result passes through accept, readiness check, one read
// step per window row of side k from the banked row store (none when k is 0),
// a read drain, and finish. An item with no result ready goes back to accept
// after the readiness check; each bank of the row store has a single read port.
// Reset (arst_n low) clears counters, controller and output valid; the row
// store holds no reset state. The finish step waits while the output register
// holds an untaken result, and input is held off until finish completes.
module padded_window_max_pool #(
	parameter int MAX_WIDTH    = pwmp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = pwmp_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_KERNEL   = pwmp_pkg::DEF_MAX_KERNEL
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	pwmp_stream_if.sink                           in_ch,
	pwmp_stream_if.source                         out_ch,
	input  logic                                  cfg_we,
	input  logic [pwmp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [pwmp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import pwmp_pkg::*;

	localparam int NB    = (MAX_KERNEL <= 2) ? 2 : 2**$clog2(MAX_KERNEL);
	localparam int NBW   = $clog2(NB);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int CHW   = $clog2(MAX_CHANNELS + 1);
	localparam int BCOLS = (MAX_WIDTH + NB - 1) / NB;
	localparam int BCW   = (BCOLS > 1) ? $clog2(BCOLS) : 1;
	localparam int CHA   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int AW    = NBW + BCW + CHA;
	localparam int SCW   = CW + 4;
	localparam int SRW   = ROW_BITS + 2;

	// configuration registers
	logic [CHAN_REG_BITS-1:0]  cfg_chan_q;
	logic [ROW_BITS-1:0]       cfg_height_q;
	logic [WIDTH_REG_BITS-1:0] cfg_width_q;
	logic [KERNEL_BITS-1:0]    cfg_kernel_q;
	logic [KERNEL_BITS-1:0]    cfg_pad_q;

	logic [CHW-1:0]         eff_c;
	logic [CW-1:0]          eff_w;
	logic [ROW_BITS-1:0]    eff_h;
	logic [KERNEL_BITS-1:0] eff_k;

	// raster counters
	logic [ROW_BITS-1:0] in_row_q, out_row_q;
	logic [CW-1:0]       in_col_q, out_col_q;
	logic [CHW-1:0]      in_chan_q, out_chan_q;

	state_t state_q, state_d;

	logic in_xfer, out_free, wr_en, restart_cfg;
	logic signed [SRW-1:0] rr_raw, r_q;
	logic signed [SCW-1:0] cc_raw, c0_q;
	logic [ROW_BITS-1:0]   rr_u;
	logic [CW-1:0]         cc_u;
	logic out_pending, out_ready_c, row_ok;
	logic [KERNEL_BITS-1:0] rcnt_q;

	logic                  rd_s1;
	logic [MAX_KERNEL-1:0] lane_ok_s1;
	logic [NBW-1:0]        lane_sel_s1 [MAX_KERNEL];

	logic [DATA_BITS-1:0]        bank_rd [NB];
	logic [AW-1:0]               bank_raddr [NB];
	logic signed [DATA_BITS-1:0] chain [MAX_KERNEL+1];
	cell_ctl_t                   cell_ctl [MAX_KERNEL];

	logic                  out_valid_q;
	out_item_t             out_data_q;
	logic                  last_c;
	logic [ROW_BITS-1:0]   out_row_n;
	logic [CW-1:0]         out_col_n;
	logic [CHW-1:0]        out_chan_n;

	// clamp the registers to the supported ranges
	always_comb begin
		if (cfg_chan_q == '0) begin
			eff_c = CHW'(1);
		end else if (int'(cfg_chan_q) > MAX_CHANNELS) begin
			eff_c = CHW'(MAX_CHANNELS);
		end else begin
			eff_c = CHW'(cfg_chan_q);
		end
		if (cfg_width_q == '0) begin
			eff_w = CW'(1);
		end else if (int'(cfg_width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(cfg_width_q);
		end
		eff_h = (cfg_height_q == '0) ? ROW_BITS'(1) : cfg_height_q;
		eff_k = (int'(cfg_kernel_q) > MAX_KERNEL) ? KERNEL_BITS'(MAX_KERNEL) : cfg_kernel_q;
	end

	// register writes; any write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_chan_q   <= CHAN_REG_BITS'(1);
			cfg_height_q <= ROW_BITS'(1);
			cfg_width_q  <= WIDTH_REG_BITS'(1);
			cfg_kernel_q <= KERNEL_BITS'(3);
			cfg_pad_q    <= KERNEL_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANNELS: cfg_chan_q   <= cfg_data[CHAN_REG_BITS-1:0];
				CFG_HEIGHT:   cfg_height_q <= cfg_data[ROW_BITS-1:0];
				CFG_WIDTH:    cfg_width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				CFG_KERNEL:   cfg_kernel_q <= cfg_data[KERNEL_BITS-1:0];
				CFG_PAD:      cfg_pad_q    <= cfg_data[KERNEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		restart_cfg = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHANNELS, CFG_HEIGHT, CFG_WIDTH, CFG_KERNEL, CFG_PAD: restart_cfg = 1'b1;
				default: restart_cfg = 1'b0;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign wr_en       = in_xfer && (in_ch.data.action == ACT_SAMPLE) && (in_row_q < eff_h);
	assign out_free    = !out_valid_q || out_ch.ready;

	// last input position of the next output's window, clipped to the map
	always_comb begin
		rr_raw = signed'(SRW'(out_row_q)) - signed'(SRW'(cfg_pad_q))
			+ signed'(SRW'(eff_k)) - signed'(SRW'(1));
		cc_raw = signed'(SCW'(out_col_q)) - signed'(SCW'(cfg_pad_q))
			+ signed'(SCW'(eff_k)) - signed'(SCW'(1));
		if (rr_raw < 0) begin
			rr_u = '0;
		end else if (rr_raw >= signed'(SRW'(eff_h))) begin
			rr_u = eff_h - ROW_BITS'(1);
		end else begin
			rr_u = rr_raw[ROW_BITS-1:0];
		end
		if (cc_raw < 0) begin
			cc_u = '0;
		end else if (cc_raw >= signed'(SCW'(eff_w))) begin
			cc_u = eff_w - CW'(1);
		end else begin
			cc_u = cc_raw[CW-1:0];
		end
		out_pending = (out_row_q < eff_h);
		out_ready_c = (rr_u < in_row_q)
			|| (rr_u == in_row_q && (cc_u < in_col_q
			|| (cc_u == in_col_q && out_chan_q < in_chan_q)));
		row_ok = (r_q >= 0) && (r_q < signed'(SRW'(eff_h)));
	end

	// next output position and frame end flag
	always_comb begin
		out_row_n  = out_row_q;
		out_col_n  = out_col_q;
		out_chan_n = out_chan_q + CHW'(1);
		if (out_chan_n >= eff_c) begin
			out_chan_n = '0;
			out_col_n  = out_col_q + CW'(1);
			if (out_col_n >= eff_w) begin
				out_col_n = '0;
				out_row_n = out_row_q + ROW_BITS'(1);
			end
		end
		last_c = (out_row_q == eff_h - ROW_BITS'(1)) && (out_col_q == eff_w - CW'(1))
			&& (out_chan_q == eff_c - CHW'(1));
	end

	// controller state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// controller next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (out_pending && out_ready_c) begin
					state_d = (eff_k == '0) ? ST_DRAIN : ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (rcnt_q + KERNEL_BITS'(1) >= eff_k) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// raster counters: advance input on a stored sample, output on finish; restart on a register write or at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_chan_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_chan_q <= '0;
		end else if (restart_cfg) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_chan_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_chan_q <= '0;
		end else if (wr_en) begin
			if (in_chan_q + CHW'(1) >= eff_c) begin
				in_chan_q <= '0;
				if (in_col_q + CW'(1) >= eff_w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_BITS'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end else begin
				in_chan_q <= in_chan_q + CHW'(1);
			end
		end else if (state_q == ST_CHECK && !(out_pending && out_ready_c)
			&& in_row_q == eff_h && out_row_q == eff_h) begin
			in_row_q  <= '0;
			out_row_q <= '0;
		end else if (state_q == ST_FINISH && out_free) begin
			if (out_row_n == eff_h && in_row_q == eff_h) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_chan_q  <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_chan_q <= '0;
			end else begin
				out_row_q  <= out_row_n;
				out_col_q  <= out_col_n;
				out_chan_q <= out_chan_n;
			end
		end
	end

	// window row walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_READ) && row_ok;
			if (state_q == ST_CHECK) begin
				rcnt_q <= '0;
			end else if (state_q == ST_READ) begin
				rcnt_q <= rcnt_q + KERNEL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			r_q  <= signed'(SRW'(out_row_q)) - signed'(SRW'(cfg_pad_q));
			c0_q <= signed'(SCW'(out_col_q)) - signed'(SCW'(cfg_pad_q));
		end else if (state_q == ST_READ) begin
			r_q <= r_q + signed'(SRW'(1));
		end
	end

	// lane bank select and bounds, held alongside the read data
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_KERNEL; j++) begin
			lane_sel_s1[j] <= c0_q[NBW-1:0] + NBW'(j);
			lane_ok_s1[j]  <= (j < int'(eff_k))
				&& (c0_q + signed'(SCW'(j)) >= 0)
				&& (c0_q + signed'(SCW'(j)) < signed'(SCW'(eff_w)));
		end
	end

	// row store: one bank per column residue, all banks read the same row
	for (genvar b = 0; b < NB; b++) begin : g_bank
		logic [NBW-1:0]        off;
		logic signed [SCW-1:0] col_b;
		logic [SCW-1:0]        col_u;

		always_comb begin
			off        = NBW'(b) - c0_q[NBW-1:0];
			col_b      = c0_q + signed'(SCW'(off));
			col_u      = col_b;
			bank_raddr[b] = {r_q[NBW-1:0], BCW'(col_u >> NBW), CHA'(out_chan_q)};
		end

		pwmp_bank #(
			.AW(AW),
			.DW(DATA_BITS)
		) u_bank (
			.clk  (clk),
			.we   (wr_en && (in_col_q[NBW-1:0] == NBW'(b))),
			.waddr({in_row_q[NBW-1:0], BCW'(in_col_q >> NBW), CHA'(in_chan_q)}),
			.wdata(in_ch.data.sample),
			.raddr(bank_raddr[b]),
			.rdata(bank_rd[b])
		);
	end

	// chain of window column cells
	assign chain[0] = DATA_MIN;

	for (genvar j = 0; j < MAX_KERNEL; j++) begin : g_cell
		assign cell_ctl[j].clr = (state_q == ST_CHECK);
		assign cell_ctl[j].en  = rd_s1 && lane_ok_s1[j];

		pwmp_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[j]),
			.din      (signed'(bank_rd[lane_sel_s1[j]])),
			.chain_in (chain[j]),
			.chain_out(chain[j+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q.pooled <= chain[MAX_KERNEL];
			out_data_q.last   <= last_c;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// a new result only comes from the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish step");

	// cells accumulate only data read in the cycle before
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> $past(state_q == ST_READ))
		else $error("cell enable without a row read");

	// counters stay within the frame
	a_rows_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_row_q <= eff_h) && (out_row_q <= eff_h))
		else $error("row counter beyond frame");

	// row walk never passes the window side
	a_rcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rcnt_q < eff_k))
		else $error("row walk past kernel");
endmodule

// File: tb/sv/pwmp_pool_checker.sv
// Checker for the padded window max pool: watches the config port and both
// stream channels, predicts each pooled result and compares it in order.
// Depends on pwmp_pkg.
module pwmp_pool_checker
	import pwmp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  in_item_t                  in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  out_item_t                 out_data,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        pending,
	output int                        failures
);

	// shadow registers
	logic [6:0]  chan_reg;
	logic [12:0] height_reg;
	logic [6:0]  width_reg;
	logic [2:0]  kernel_reg;
	logic [2:0]  pad_reg;

	// ring of recent rows and the raster positions of both sides
	logic signed [DATA_BITS-1:0] pix_store [16][64][64];
	int in_row, in_col, in_chan, in_cnt;
	int out_row, out_col, out_chan, out_cnt;

	out_item_t pooled_q[$];

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic restart_frame();
		in_row = 0; in_col = 0; in_chan = 0; in_cnt = 0;
		out_row = 0; out_col = 0; out_chan = 0; out_cnt = 0;
	endtask

	// advance the predictor by one accepted input transfer
	task automatic predict_pool(in_item_t item);
		int nc, nw, nh, nk, np, total, rr, cc, idx, best, r, c;
		bit avail;
		out_item_t res;
		nc = chan_reg == 0 ? 1 : (chan_reg > 64 ? 64 : int'(chan_reg));
		nw = width_reg == 0 ? 1 : (width_reg > 64 ? 64 : int'(width_reg));
		nh = height_reg == 0 ? 1 : int'(height_reg);
		nk = kernel_reg > 5 ? 5 : int'(kernel_reg);
		np = int'(pad_reg);
		total = nh * nw * nc;

		// store the sample and step the input raster position
		if (item.action == ACT_SAMPLE && in_cnt < total) begin
			pix_store[in_row % 16][in_col][in_chan] = item.sample;
			in_cnt++;
			in_chan++;
			if (in_chan >= nc) begin
				in_chan = 0;
				in_col++;
				if (in_col >= nw) begin
					in_col = 0;
					in_row++;
				end
			end
		end

		// emit the next output if its whole window has arrived
		if (out_cnt < total) begin
			if (in_cnt >= total) avail = 1;
			else begin
				rr = clip(out_row - np + nk - 1, 0, nh - 1);
				cc = clip(out_col - np + nk - 1, 0, nw - 1);
				idx = (rr * nw + cc) * nc + out_chan;
				avail = idx < in_cnt;
			end
			if (avail) begin
				best = -32768;
				for (r = out_row - np; r < out_row - np + nk; r++) begin
					if (r < 0 || r >= nh) continue;
					for (c = out_col - np; c < out_col - np + nk; c++) begin
						if (c < 0 || c >= nw) continue;
						if (int'(pix_store[r % 16][c][out_chan]) > best)
							best = pix_store[r % 16][c][out_chan];
					end
				end
				out_cnt++;
				res.pooled = best[DATA_BITS-1:0];
				res.last = out_cnt == total;
				pooled_q.push_back(res);
				out_chan++;
				if (out_chan >= nc) begin
					out_chan = 0;
					out_col++;
					if (out_col >= nw) begin
						out_col = 0;
						out_row++;
					end
				end
			end
		end

		if (in_cnt >= total && out_cnt >= total) restart_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			chan_reg = 1; height_reg = 1; width_reg = 1; kernel_reg = 3; pad_reg = 1;
			restart_frame();
			pooled_q.delete();
			failures = 0;
			pending = 0;
		end else begin
			// any register write restarts the frame
			if (cfg_we) begin
				case (cfg_index)
					CFG_CHANNELS: begin chan_reg = cfg_data[6:0]; restart_frame(); end
					CFG_HEIGHT:   begin height_reg = cfg_data[12:0]; restart_frame(); end
					CFG_WIDTH:    begin width_reg = cfg_data[6:0]; restart_frame(); end
					CFG_KERNEL:   begin kernel_reg = cfg_data[2:0]; restart_frame(); end
					CFG_PAD:      begin pad_reg = cfg_data[2:0]; restart_frame(); end
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_pool(in_data);
			if (out_valid && out_ready) begin
				if (pooled_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: pooled %0d last %0b",
							out_data.pooled, out_data.last);
				end else begin
					want = pooled_q.pop_front();
					if (out_data.pooled !== want.pooled || out_data.last !== want.last) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: pooled exp %0d got %0d, last exp %0b got %0b",
								want.pooled, out_data.pooled, want.last, out_data.last);
					end
				end
			end
			pending = pooled_q.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// Top of the padded window max pool testbench: clock, reset, stimulus through
// the stream channels and config port, and the verdict.
// Depends on pwmp_pkg, pwmp_stream_if, padded_window_max_pool, pwmp_pool_checker.
module tb_top;
	import pwmp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	int                        pending, failures;
	int                        cycles = 0;
	int                        items_sent = 0;
	bit                        hold_req = 0;

	pwmp_stream_if #(.payload_t(in_item_t))  in_ch();
	pwmp_stream_if #(.payload_t(out_item_t)) out_ch();

	padded_window_max_pool u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwmp_pool_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.failures  (failures)
	);

	always #1 clk = ~clk;

	// end the run at the cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [DATA_BITS-1:0] pick_sample();
		case ($urandom_range(0, 19))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return DATA_BITS'($urandom);
		endcase
	endfunction

	// receiver: random ready, with one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && out_ch.valid) begin
				hold_req = 0;
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				if ($urandom_range(0, 1)) begin
					out_ch.ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
			end
		end
	end

	// offer one item and hold it until the transfer
	task automatic transfer_in(logic act, logic signed [DATA_BITS-1:0] s);
		int gap;
		in_item_t item;
		gap = pick_gap();
		item.action = act;
		item.sample = s;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= item;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_BITS-1:0];
		@(posedge clk);
	endtask

	// wait for the block to go idle, then write all registers
	task automatic set_config(int c, int h, int w, int k, int p);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);
		cfg_write(CFG_CHANNELS, c);
		cfg_write(CFG_HEIGHT, h);
		cfg_write(CFG_WIDTH, w);
		cfg_write(CFG_KERNEL, k);
		cfg_write(CFG_PAD, p);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one frame: n items, mostly samples, then a drain tail
	task automatic run_frame(int c, int h, int w, int k, int p, int n, bit pause_mid);
		int ec, ew, eh, total, tail, i;
		set_config(c, h, w, k, p);
		ec = c == 0 ? 1 : (c > 64 ? 64 : c);
		ew = w == 0 ? 1 : (w > 64 ? 64 : w);
		eh = h == 0 ? 1 : h;
		total = ec * ew * eh;
		for (i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			transfer_in($urandom_range(0, 7) == 0 ? ACT_DRAIN : ACT_SAMPLE, pick_sample());
		end
		tail = n < total ? 3 : (total < 6 * ew * ec + 2 ? total : 6 * ew * ec + 2);
		for (i = 0; i < tail; i++)
			transfer_in($urandom_range(0, 4) == 0 ? ACT_SAMPLE : ACT_DRAIN, pick_sample());
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		int c, h, w, k, p, n;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-sample frames at the data extremes
		transfer_in(ACT_SAMPLE, 16'sh7FFF);
		transfer_in(ACT_DRAIN, 16'sh0000);
		transfer_in(ACT_SAMPLE, 16'sh8000);
		transfer_in(ACT_DRAIN, 16'shFFFF);
		transfer_in(ACT_SAMPLE, 16'shFFFF);

		// directed settings, including clamped and empty windows
		hold_req = 1;
		run_frame(5, 3, 4, 3, 1, 60, 0);
		run_frame(2, 4, 3, 1, 0, 24, 0);
		run_frame(1, 5, 5, 5, 4, 25, 1);
		run_frame(1, 5, 5, 5, 0, 25, 0);
		run_frame(2, 2, 2, 0, 0, 8, 0);
		run_frame(1, 3, 3, 3, 7, 9, 0);
		run_frame(0, 0, 0, 7, 2, 1, 0);
		run_frame(64, 1, 1, 3, 1, 24, 0);
		run_frame(127, 1, 1, 2, 1, 24, 0);
		run_frame(1, 1, 64, 3, 2, 24, 0);
		run_frame(1, 1, 127, 4, 3, 24, 0);
		run_frame(1, 4096, 1, 5, 2, 60, 0);

		// random small frames, a few partial
		while (items_sent < 520) begin
			c = $urandom_range(1, 4);
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5);
			p = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) :
				(k == 0 ? 0 : $urandom_range(0, k - 1));
			n = $urandom_range(0, 4) == 0 ? $urandom_range(1, c * w * h) : c * w * h;
			run_frame(c, h, w, k, p, n, $urandom_range(0, 9) == 0);
		end

		@(posedge clk);
		wait (pending == 0);
		repeat (30) @(posedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
